// File: rtl/rbaa_pkg.sv
// ----------------------------------------------------------------------------
// rbaa_pkg
// Shared constants, types and saturating helpers for the rigid-body angular
// acceleration pipeline.
// ----------------------------------------------------------------------------
package rbaa_pkg;

    // number formats
    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;
    localparam int ACC_W     = 64;

    // fixed-point one, reset value of the diagonal elements
    localparam logic [WORD_BITS-2:0] FX_ONE = (WORD_BITS-1)'(1) << FRAC_BITS;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_IXX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IYY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IZZ = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IXY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IXZ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IYZ = 3'd5;

    // divider: quotient bits kept, and the shift that forms the first remainder
    localparam int QBITS  = WORD_BITS + 1;
    localparam int DIV_SH = QBITS - FRAC_BITS;

    // pipeline latencies
    localparam int MUL_LAT = 4;
    localparam int DIV_LAT = QBITS + 2;
    localparam int W_DLY   = MUL_LAT + 1;
    localparam int T_DLY   = 2 * MUL_LAT + 2;
    localparam int LAT     = 3 * MUL_LAT + 4 + DIV_LAT;

    typedef logic signed [ACC_W-1:0]     t_acc;
    typedef logic signed [WORD_BITS-1:0] t_word;

    // tensor elements, cofactors and determinant as seen by the datapath
    typedef struct packed {
        t_acc ixx;
        t_acc iyy;
        t_acc izz;
        t_acc ixy;
        t_acc ixz;
        t_acc iyz;
        t_acc cxx;
        t_acc cxy;
        t_acc cxz;
        t_acc cyy;
        t_acc cyz;
        t_acc czz;
        t_acc det;
        logic singular;
    } t_inertia;

    localparam t_acc ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    function automatic t_acc sext_word(input t_word w);
        sext_word = {{(ACC_W-WORD_BITS){w[WORD_BITS-1]}}, w};
    endfunction

    function automatic t_acc sat_add(input t_acc a, input t_acc b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_add = s[ACC_W-1:0];
        end
    endfunction

    function automatic t_acc sat_sub(input t_acc a, input t_acc b);
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            sat_sub = s[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sat_sub = s[ACC_W-1:0];
        end
    endfunction

endpackage

// File: rtl/rigid_body_angular_accel.sv
// ----------------------------------------------------------------------------
// rigid_body_angular_accel
// Angular acceleration of a rigid body from Euler's equations, Q16.16.
// ----------------------------------------------------------------------------
// Input words carry omega and torque (i_valid / o_stall); result words carry
// accel and the singular flag (o_valid / i_stall). A word moves on a clock
// edge with valid high and stall low. The inertia tensor is written through
// i_cfg_we / i_cfg_idx / i_cfg_data; unknown indexes are dropped.
// The datapath is a 4-stage multiplier three times over (L = I.omega,
// omega x L, adj(I).r), four sum stages, and a 35-stage divider that settles
// one quotient bit a stage. One word is taken every cycle while not stalled.
// Cofactors and the determinant come from a pipeline on the registers;
// it is settled before any word taken after a write needs them.
// Reset (synchronous, active low) empties the pipeline and loads the
// identity tensor. While a result waits under stall the whole pipeline
// holds and o_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rigid_body_angular_accel (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_omega_x,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_omega_y,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_omega_z,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_torque_x,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_torque_y,
    input  logic signed [rbaa_pkg::WORD_BITS-1:0] i_torque_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_x,
    output logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_y,
    output logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_z,
    output logic                                 o_singular,
    input  logic                                 i_cfg_we,
    input  logic [rbaa_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [rbaa_pkg::WORD_BITS-1:0]       i_cfg_data
);

    localparam int WB  = rbaa_pkg::WORD_BITS;
    localparam int LAT = rbaa_pkg::LAT;

    rbaa_pkg::t_inertia cfg;

    logic           adv;
    logic           r_vld [1:LAT];
    logic           r_sing;

    rbaa_pkg::t_acc w0 [3];
    rbaa_pkg::t_acc w5 [3];
    rbaa_pkg::t_acc t10 [3];
    logic [3*WB-1:0] w_dly, t_dly;

    rbaa_pkg::t_acc la [9];
    rbaa_pkg::t_acc lb [9];
    rbaa_pkg::t_acc lp [9];
    rbaa_pkg::t_acc r_l [3];
    rbaa_pkg::t_acc xa [6];
    rbaa_pkg::t_acc xb [6];
    rbaa_pkg::t_acc xp [6];
    rbaa_pkg::t_acc r_d [3];
    rbaa_pkg::t_acc r_r [3];
    rbaa_pkg::t_acc na [9];
    rbaa_pkg::t_acc nb [9];
    rbaa_pkg::t_acc np [9];
    rbaa_pkg::t_acc r_n [3];
    rbaa_pkg::t_word quo [3];

    // global advance: hold everything while the output word is stalled
    assign adv     = !(r_vld[LAT] && i_stall);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    rbaa_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_inertia  (cfg)
    );

    assign w0[0] = rbaa_pkg::sext_word(i_omega_x);
    assign w0[1] = rbaa_pkg::sext_word(i_omega_y);
    assign w0[2] = rbaa_pkg::sext_word(i_omega_z);

    // omega and torque travel alongside the products
    rbaa_delay #(.WIDTH(3*WB), .DEPTH(rbaa_pkg::W_DLY)) u_wdly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({i_omega_x, i_omega_y, i_omega_z}),
        .o_q   (w_dly)
    );

    rbaa_delay #(.WIDTH(3*WB), .DEPTH(rbaa_pkg::T_DLY)) u_tdly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({i_torque_x, i_torque_y, i_torque_z}),
        .o_q   (t_dly)
    );

    assign w5[0]  = rbaa_pkg::sext_word(w_dly[3*WB-1:2*WB]);
    assign w5[1]  = rbaa_pkg::sext_word(w_dly[2*WB-1:WB]);
    assign w5[2]  = rbaa_pkg::sext_word(w_dly[WB-1:0]);
    assign t10[0] = rbaa_pkg::sext_word(t_dly[3*WB-1:2*WB]);
    assign t10[1] = rbaa_pkg::sext_word(t_dly[2*WB-1:WB]);
    assign t10[2] = rbaa_pkg::sext_word(t_dly[WB-1:0]);

    // angular momentum L = I . omega
    always_comb begin
        la[0] = cfg.ixx; la[1] = cfg.ixy; la[2] = cfg.ixz;
        la[3] = cfg.ixy; la[4] = cfg.iyy; la[5] = cfg.iyz;
        la[6] = cfg.ixz; la[7] = cfg.iyz; la[8] = cfg.izz;
        for (int k = 0; k < 9; k++) begin
            lb[k] = w0[k % 3];
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_lmul
        rbaa_fxmul u_mul (.i_clk(i_clk), .i_en(adv), .i_a(la[k]), .i_b(lb[k]), .o_p(lp[k]));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_l[k] <= rbaa_pkg::sat_add(rbaa_pkg::sat_add(lp[3*k], lp[3*k+1]),
                                            lp[3*k+2]);
            end
        end
    end

    // omega x L, in pairs: first minus second
    always_comb begin
        xa[0] = w5[1]; xb[0] = r_l[2];
        xa[1] = w5[2]; xb[1] = r_l[1];
        xa[2] = w5[2]; xb[2] = r_l[0];
        xa[3] = w5[0]; xb[3] = r_l[2];
        xa[4] = w5[0]; xb[4] = r_l[1];
        xa[5] = w5[1]; xb[5] = r_l[0];
    end

    for (genvar k = 0; k < 6; k++) begin : g_xmul
        rbaa_fxmul u_mul (.i_clk(i_clk), .i_en(adv), .i_a(xa[k]), .i_b(xb[k]), .o_p(xp[k]));
    end

    // r = torque - omega x L
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= rbaa_pkg::sat_sub(xp[2*k], xp[2*k+1]);
                r_r[k] <= rbaa_pkg::sat_sub(t10[k], r_d[k]);
            end
        end
    end

    // n = adj(I) . r
    always_comb begin
        na[0] = cfg.cxx; na[1] = cfg.cxy; na[2] = cfg.cxz;
        na[3] = cfg.cxy; na[4] = cfg.cyy; na[5] = cfg.cyz;
        na[6] = cfg.cxz; na[7] = cfg.cyz; na[8] = cfg.czz;
        for (int k = 0; k < 9; k++) begin
            nb[k] = r_r[k % 3];
        end
    end

    for (genvar k = 0; k < 9; k++) begin : g_nmul
        rbaa_fxmul u_mul (.i_clk(i_clk), .i_en(adv), .i_a(na[k]), .i_b(nb[k]), .o_p(np[k]));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= rbaa_pkg::sat_add(rbaa_pkg::sat_add(np[3*k], np[3*k+1]),
                                            np[3*k+2]);
            end
        end
    end

    // accel = n / det
    for (genvar k = 0; k < 3; k++) begin : g_div
        rbaa_div u_div (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_num  (r_n[k]),
            .i_den  (cfg.det),
            .i_zero (cfg.singular),
            .o_quo  (quo[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sing <= cfg.singular;
        end
    end

    assign o_valid    = r_vld[LAT];
    assign o_accel_x  = quo[0];
    assign o_accel_y  = quo[1];
    assign o_accel_z  = quo[2];
    assign o_singular = r_sing;

endmodule

// File: rtl/rbaa_fxmul.sv
// ----------------------------------------------------------------------------
// rbaa_fxmul
// Four-stage fixed-point multiplier: magnitudes, four 32x32 partial products,
// sum with rounding constant, then shift, saturate and restore sign.
// ----------------------------------------------------------------------------
module rbaa_fxmul (
    input  logic            i_clk,
    input  logic            i_en,
    input  rbaa_pkg::t_acc  i_a,
    input  rbaa_pkg::t_acc  i_b,
    output rbaa_pkg::t_acc  o_p
);

    localparam int AW = rbaa_pkg::ACC_W;
    localparam int HW = AW / 2;

    logic [AW-1:0]   r_am, r_bm;
    logic            r_neg1, r_neg2, r_neg3;
    logic [AW-1:0]   r_p00, r_p01, r_p10, r_p11;
    logic [2*AW-1:0] r_sum;
    rbaa_pkg::t_acc  r_p;

    logic [2*AW-1:0] n_sum;
    logic [2*AW-1:0] rr;
    logic [AW-1:0]   lim, mag;

    // stage 1: sign and magnitudes
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am   <= i_a[AW-1] ? (~i_a + 1'b1) : i_a;
            r_bm   <= i_b[AW-1] ? (~i_b + 1'b1) : i_b;
            r_neg1 <= i_a[AW-1] ^ i_b[AW-1];
        end
    end

    // stage 2: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00  <= r_am[HW-1:0]  * r_bm[HW-1:0];
            r_p01  <= r_am[HW-1:0]  * r_bm[AW-1:HW];
            r_p10  <= r_am[AW-1:HW] * r_bm[HW-1:0];
            r_p11  <= r_am[AW-1:HW] * r_bm[AW-1:HW];
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: full product plus half an lsb
    always_comb begin
        n_sum = {{AW{1'b0}}, r_p00}
              + ({{AW{1'b0}}, r_p01} << HW)
              + ({{AW{1'b0}}, r_p10} << HW)
              + {r_p11, {AW{1'b0}}}
              + ((2*AW)'(1) << (rbaa_pkg::FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= n_sum;
            r_neg3 <= r_neg2;
        end
    end

    // stage 4: drop fraction, clamp magnitude, apply sign
    always_comb begin
        rr  = r_sum >> rbaa_pkg::FRAC_BITS;
        lim = r_neg3 ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        mag = ((|rr[2*AW-1:AW]) || (rr[AW-1:0] > lim)) ? lim : rr[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg3 ? (~mag + 1'b1) : mag;
        end
    end

    assign o_p = r_p;

endmodule

// File: rtl/rbaa_delay.sv
// ----------------------------------------------------------------------------
// rbaa_delay
// Stallable register line that keeps operands level with the datapath.
// ----------------------------------------------------------------------------
module rbaa_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// File: rtl/rbaa_div.sv
// ----------------------------------------------------------------------------
// rbaa_div
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit a
// stage, rounded half away from zero and saturated to the word range.
// ----------------------------------------------------------------------------
module rbaa_div (
    input  logic             i_clk,
    input  logic             i_en,
    input  rbaa_pkg::t_acc   i_num,
    input  rbaa_pkg::t_acc   i_den,
    input  logic             i_zero,
    output rbaa_pkg::t_word  o_quo
);

    localparam int AW = rbaa_pkg::ACC_W;
    localparam int QB = rbaa_pkg::QBITS;
    localparam int SH = rbaa_pkg::DIV_SH;
    localparam int WB = rbaa_pkg::WORD_BITS;

    logic [AW-1:0] dm, nm;
    logic [AW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_sh  [QB+1];
    logic          r_ovf [QB+1];
    logic          r_neg [QB+1];
    rbaa_pkg::t_word r_quo;

    logic [QB:0]   q_rnd, lim, mag;
    logic          rup;

    // divisor magnitude is static between configuration writes
    assign dm = i_den[AW-1] ? (~i_den + 1'b1) : i_den;
    assign nm = i_num[AW-1] ? (~i_num + 1'b1) : i_num;

    // prep: quotient too wide for the kept bits means saturation
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= (nm >> SH) >= dm;
            r_rem[0] <= ((nm >> SH) >= dm) ? '0 : (nm >> SH);
            r_sh[0]  <= {nm[SH-1:0], {rbaa_pkg::FRAC_BITS{1'b0}}};
            r_neg[0] <= i_num[AW-1] ^ i_den[AW-1];
        end
    end

    // one quotient bit per stage; dividend bits shift out as quotient shifts in
    for (genvar k = 0; k < QB; k++) begin : g_step
        logic [AW:0] trial;
        logic        ge;

        always_comb begin
            trial = {r_rem[k], r_sh[k][QB-1]};
            ge    = trial >= {1'b0, dm};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= ge ? AW'(trial - {1'b0, dm}) : trial[AW-1:0];
                r_sh[k+1]  <= {r_sh[k][QB-2:0], ge};
                r_ovf[k+1] <= r_ovf[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    // round, saturate, sign
    always_comb begin
        rup   = r_rem[QB] >= (dm - r_rem[QB]);
        q_rnd = {1'b0, r_sh[QB]} + (QB+1)'(rup);
        lim   = r_neg[QB] ? ((QB+1)'(1) << (WB-1)) : (((QB+1)'(1) << (WB-1)) - 1'b1);
        mag   = (r_ovf[QB] || (q_rnd > lim)) ? lim : q_rnd;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_zero) begin
                r_quo <= '0;
            end else if (r_neg[QB]) begin
                r_quo <= ~mag[WB-1:0] + 1'b1;
            end else begin
                r_quo <= mag[WB-1:0];
            end
        end
    end

    assign o_quo = r_quo;

endmodule

// File: rtl/rbaa_cfg.sv
// ----------------------------------------------------------------------------
// rbaa_cfg
// Inertia registers plus a free-running pipeline that derives the cofactors
// and the determinant from them.
// ----------------------------------------------------------------------------
module rbaa_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rbaa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rbaa_pkg::WORD_BITS-1:0]    i_cfg_data,
    output rbaa_pkg::t_inertia                o_inertia
);

    localparam int WB = rbaa_pkg::WORD_BITS;
    localparam int AW = rbaa_pkg::ACC_W;

    logic [WB-2:0] r_ixx, r_iyy, r_izz;
    logic [WB-1:0] r_ixy, r_ixz, r_iyz;

    rbaa_pkg::t_acc ixx, iyy, izz, ixy, ixz, iyz;
    rbaa_pkg::t_acc ca [12];
    rbaa_pkg::t_acc cb [12];
    rbaa_pkg::t_acc cp [12];
    rbaa_pkg::t_acc r_cof [6];
    rbaa_pkg::t_acc dp [3];
    rbaa_pkg::t_acc r_det;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ixx <= rbaa_pkg::FX_ONE;
            r_iyy <= rbaa_pkg::FX_ONE;
            r_izz <= rbaa_pkg::FX_ONE;
            r_ixy <= '0;
            r_ixz <= '0;
            r_iyz <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbaa_pkg::REG_IXX: r_ixx <= i_cfg_data[WB-2:0];
                rbaa_pkg::REG_IYY: r_iyy <= i_cfg_data[WB-2:0];
                rbaa_pkg::REG_IZZ: r_izz <= i_cfg_data[WB-2:0];
                rbaa_pkg::REG_IXY: r_ixy <= i_cfg_data;
                rbaa_pkg::REG_IXZ: r_ixz <= i_cfg_data;
                rbaa_pkg::REG_IYZ: r_iyz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign ixx = {{(AW-WB+1){1'b0}}, r_ixx};
    assign iyy = {{(AW-WB+1){1'b0}}, r_iyy};
    assign izz = {{(AW-WB+1){1'b0}}, r_izz};
    assign ixy = rbaa_pkg::sext_word(r_ixy);
    assign ixz = rbaa_pkg::sext_word(r_ixz);
    assign iyz = rbaa_pkg::sext_word(r_iyz);

    // cofactor products, in pairs: first minus second
    always_comb begin
        ca[0]  = iyy; cb[0]  = izz;  ca[1]  = iyz; cb[1]  = iyz;
        ca[2]  = ixz; cb[2]  = iyz;  ca[3]  = ixy; cb[3]  = izz;
        ca[4]  = ixy; cb[4]  = iyz;  ca[5]  = iyy; cb[5]  = ixz;
        ca[6]  = ixx; cb[6]  = izz;  ca[7]  = ixz; cb[7]  = ixz;
        ca[8]  = ixy; cb[8]  = ixz;  ca[9]  = ixx; cb[9]  = iyz;
        ca[10] = ixx; cb[10] = iyy;  ca[11] = ixy; cb[11] = ixy;
    end

    for (genvar k = 0; k < 12; k++) begin : g_cmul
        rbaa_fxmul u_mul (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_a   (ca[k]),
            .i_b   (cb[k]),
            .o_p   (cp[k])
        );
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_cof[k] <= rbaa_pkg::sat_sub(cp[2*k], cp[2*k+1]);
        end
    end

    // determinant along the first row
    rbaa_fxmul u_dmul0 (.i_clk(i_clk), .i_en(1'b1), .i_a(ixx), .i_b(r_cof[0]), .o_p(dp[0]));
    rbaa_fxmul u_dmul1 (.i_clk(i_clk), .i_en(1'b1), .i_a(ixy), .i_b(r_cof[1]), .o_p(dp[1]));
    rbaa_fxmul u_dmul2 (.i_clk(i_clk), .i_en(1'b1), .i_a(ixz), .i_b(r_cof[2]), .o_p(dp[2]));

    always_ff @(posedge i_clk) begin
        r_det <= rbaa_pkg::sat_add(rbaa_pkg::sat_add(dp[0], dp[1]), dp[2]);
    end

    always_comb begin
        o_inertia.ixx      = ixx;
        o_inertia.iyy      = iyy;
        o_inertia.izz      = izz;
        o_inertia.ixy      = ixy;
        o_inertia.ixz      = ixz;
        o_inertia.iyz      = iyz;
        o_inertia.cxx      = r_cof[0];
        o_inertia.cxy      = r_cof[1];
        o_inertia.cxz      = r_cof[2];
        o_inertia.cyy      = r_cof[3];
        o_inertia.cyz      = r_cof[4];
        o_inertia.czz      = r_cof[5];
        o_inertia.det      = r_det;
        o_inertia.singular = (r_det == '0);
    end

endmodule

// File: rtl/rbaa_chk.sv
// ----------------------------------------------------------------------------
// rbaa_chk
// Port-level checks on the angular acceleration block, bound to the top.
// ----------------------------------------------------------------------------
module rbaa_chk (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_stall,
    input logic                                 o_valid,
    input logic                                 i_stall,
    input logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_x,
    input logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_y,
    input logic signed [rbaa_pkg::WORD_BITS-1:0] o_accel_z,
    input logic                                 o_singular
);

    // a stalled result word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_accel_x) && $stable(o_accel_y)
                               && $stable(o_accel_z) && $stable(o_singular))
        else $error("stalled result word changed");

    // input backpressure only ever comes from a blocked output
    a_stall_src: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // singular results carry zero accelerations
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_singular |-> o_accel_x == '0 && o_accel_y == '0 && o_accel_z == '0)
        else $error("singular word with non-zero acceleration");

    // reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result word shown after reset");

endmodule

bind rigid_body_angular_accel rbaa_chk u_chk (.*);

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for rigid_body_angular_accel. Directed words,
// then randomly configured phases of random words, are pushed through the
// block. Each result word is compared field by field with a table entry or
// a fixed-point Euler prediction. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int             N_PHASE   = 7;
    localparam int             PHASE_LEN = 250;
    localparam rbaa_pkg::t_word W_MAX    = 32'sh7FFF_FFFF;
    localparam rbaa_pkg::t_word W_MIN    = 32'sh8000_0000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [rbaa_pkg::CFG_IDX_W-1:0]     idx;
        logic [rbaa_pkg::WORD_BITS-1:0]     val;
        rbaa_pkg::t_word                    wx, wy, wz, tx, ty, tz;
        logic                               typed;
        rbaa_pkg::t_word                    ex, ey, ez;
        logic                               es;
    } t_dir_row;

    typedef struct {
        rbaa_pkg::t_word ax, ay, az;
        logic            sing;
    } t_accel;

    localparam int N_DIR = 24;
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        // identity tensor straight after reset
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 0, 0, 0, 32'sh10000, -32'sh10000, 32'sh8000,
          1'b1, 32'sh10000, -32'sh10000, 32'sh8000, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 0, 0, 0, W_MAX, W_MIN, 0,
          1'b1, W_MAX, W_MIN, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 32'sh10000, 32'sh20000, 32'sh30000, 0, 0, 0,
          1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, 1,
          1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
          1'b0, 0, 0, 0, 1'b0},
        // indexes past the last register are dropped
        '{ROW_CFG, 3'd6, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, 3'd7, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 0, 0, 0, 32'sh20000, 32'sh30000, 32'sh40000,
          1'b1, 32'sh20000, 32'sh30000, 32'sh40000, 1'b0},
        // general tensor
        '{ROW_CFG, rbaa_pkg::REG_IXX, 32'h0002_0000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IYY, 32'h0004_0000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IZZ, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IXY, 32'h0000_4000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IXZ, 32'hFFFF_E000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IYZ, 32'h0000_8000, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 32'sh10000, -32'sh8000, 32'sh30000, 32'sh50000,
          -32'sh20000, 32'sh1234, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, -32'sh7000, 32'sh18000, 32'sh0, 0, 0, 32'sh10000,
          1'b0, 0, 0, 0, 1'b0},
        // singular tensor: zero everywhere but yy and zz
        '{ROW_CFG, rbaa_pkg::REG_IXY, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IXZ, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IYZ, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_CFG, rbaa_pkg::REG_IXX, 32'h0, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, 0, 0, 0, 32'sh10000, 0, 0, 1'b1, 0, 0, 0, 1'b1},
        '{ROW_ITEM, rbaa_pkg::REG_IXX, 0, W_MAX, W_MIN, W_MAX, W_MAX, W_MAX, W_MIN,
          1'b1, 0, 0, 0, 1'b1},
        // diagonal at full scale, top data bit must be dropped
        '{ROW_CFG, rbaa_pkg::REG_IXX, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0, 0, 0, 0, 1'b0}
    };

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    rbaa_pkg::t_word                    i_omega_x = '0, i_omega_y = '0, i_omega_z = '0;
    rbaa_pkg::t_word                    i_torque_x = '0, i_torque_y = '0, i_torque_z = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    rbaa_pkg::t_word                    o_accel_x, o_accel_y, o_accel_z;
    logic                               o_singular;
    logic                               i_cfg_we = 1'b0;
    logic [rbaa_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [rbaa_pkg::WORD_BITS-1:0]     i_cfg_data = '0;

    // tensor as the predictor sees it
    logic [rbaa_pkg::WORD_BITS-2:0]     tn_xx = rbaa_pkg::FX_ONE;
    logic [rbaa_pkg::WORD_BITS-2:0]     tn_yy = rbaa_pkg::FX_ONE;
    logic [rbaa_pkg::WORD_BITS-2:0]     tn_zz = rbaa_pkg::FX_ONE;
    rbaa_pkg::t_word                    tn_xy = '0, tn_xz = '0, tn_yz = '0;

    t_accel                             accel_q [$];
    int                                 n_err = 0;
    bit                                 calm = 1'b0;

    rigid_body_angular_accel dut (.*);

    always #2 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ---- fixed-point arithmetic, 64-bit intermediates ----
    function automatic rbaa_pkg::t_acc add_sat(rbaa_pkg::t_acc a, rbaa_pkg::t_acc b);
        logic signed [rbaa_pkg::ACC_W:0] s;
        s = {a[rbaa_pkg::ACC_W-1], a} + {b[rbaa_pkg::ACC_W-1], b};
        if (s > $signed({2'b00, rbaa_pkg::ACC_MAX})) return rbaa_pkg::ACC_MAX;
        if (s < $signed({1'b1, rbaa_pkg::ACC_MIN})) return rbaa_pkg::ACC_MIN;
        return s[rbaa_pkg::ACC_W-1:0];
    endfunction

    function automatic rbaa_pkg::t_acc sub_sat(rbaa_pkg::t_acc a, rbaa_pkg::t_acc b);
        logic signed [rbaa_pkg::ACC_W:0] s;
        s = {a[rbaa_pkg::ACC_W-1], a} - {b[rbaa_pkg::ACC_W-1], b};
        if (s > $signed({2'b00, rbaa_pkg::ACC_MAX})) return rbaa_pkg::ACC_MAX;
        if (s < $signed({1'b1, rbaa_pkg::ACC_MIN})) return rbaa_pkg::ACC_MIN;
        return s[rbaa_pkg::ACC_W-1:0];
    endfunction

    function automatic logic [63:0] magn(rbaa_pkg::t_acc a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    // product rounded half away from zero, then saturated
    function automatic rbaa_pkg::t_acc qmul(rbaa_pkg::t_acc a, rbaa_pkg::t_acc b);
        logic         neg;
        logic [127:0] p;
        logic [63:0]  lim;
        neg = a[63] ^ b[63];
        p   = {64'b0, magn(a)} * {64'b0, magn(b)};
        p   = (p + (128'd1 << (rbaa_pkg::FRAC_BITS - 1))) >> rbaa_pkg::FRAC_BITS;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (p > {64'b0, lim}) p = {64'b0, lim};
        return neg ? -rbaa_pkg::t_acc'(p[63:0]) : rbaa_pkg::t_acc'(p[63:0]);
    endfunction

    function automatic rbaa_pkg::t_acc dot(rbaa_pkg::t_acc a0, rbaa_pkg::t_acc a1,
                                           rbaa_pkg::t_acc a2, rbaa_pkg::t_acc b0,
                                           rbaa_pkg::t_acc b1, rbaa_pkg::t_acc b2);
        return add_sat(add_sat(qmul(a0, b0), qmul(a1, b1)), qmul(a2, b2));
    endfunction

    // (n << FRAC_BITS) / d, rounded, saturated to a word
    function automatic rbaa_pkg::t_word qdiv(rbaa_pkg::t_acc n, rbaa_pkg::t_acc d);
        logic         neg;
        logic [127:0] num, dm, q, rem;
        neg = n[63] ^ d[63];
        num = {64'b0, magn(n)} << rbaa_pkg::FRAC_BITS;
        dm  = {64'b0, magn(d)};
        q   = num / dm;
        rem = num % dm;
        if (rem >= dm - rem) q = q + 1;
        if (neg && q > 128'h8000_0000) q = 128'h8000_0000;
        if (!neg && q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
        return neg ? -rbaa_pkg::t_word'(q[31:0]) : rbaa_pkg::t_word'(q[31:0]);
    endfunction

    function automatic t_accel euler_accel(rbaa_pkg::t_word wxw, wyw, wzw, txw, tyw, tzw);
        rbaa_pkg::t_acc wx, wy, wz, ixx, iyy, izz, ixy, ixz, iyz;
        rbaa_pkg::t_acc lx, ly, lz, rx, ry, rz, cxx, cxy, cxz, cyy, cyz, czz, det;
        t_accel         res;
        wx  = rbaa_pkg::sext_word(wxw);
        wy  = rbaa_pkg::sext_word(wyw);
        wz  = rbaa_pkg::sext_word(wzw);
        ixx = rbaa_pkg::t_acc'(tn_xx);
        iyy = rbaa_pkg::t_acc'(tn_yy);
        izz = rbaa_pkg::t_acc'(tn_zz);
        ixy = rbaa_pkg::sext_word(tn_xy);
        ixz = rbaa_pkg::sext_word(tn_xz);
        iyz = rbaa_pkg::sext_word(tn_yz);
        lx  = dot(ixx, ixy, ixz, wx, wy, wz);
        ly  = dot(ixy, iyy, iyz, wx, wy, wz);
        lz  = dot(ixz, iyz, izz, wx, wy, wz);
        rx  = sub_sat(rbaa_pkg::sext_word(txw), sub_sat(qmul(wy, lz), qmul(wz, ly)));
        ry  = sub_sat(rbaa_pkg::sext_word(tyw), sub_sat(qmul(wz, lx), qmul(wx, lz)));
        rz  = sub_sat(rbaa_pkg::sext_word(tzw), sub_sat(qmul(wx, ly), qmul(wy, lx)));
        cxx = sub_sat(qmul(iyy, izz), qmul(iyz, iyz));
        cxy = sub_sat(qmul(ixz, iyz), qmul(ixy, izz));
        cxz = sub_sat(qmul(ixy, iyz), qmul(iyy, ixz));
        cyy = sub_sat(qmul(ixx, izz), qmul(ixz, ixz));
        cyz = sub_sat(qmul(ixy, ixz), qmul(ixx, iyz));
        czz = sub_sat(qmul(ixx, iyy), qmul(ixy, ixy));
        det = dot(ixx, ixy, ixz, cxx, cxy, cxz);
        if (det == 0) begin
            res = '{0, 0, 0, 1'b1};
        end else begin
            res.ax   = qdiv(dot(cxx, cxy, cxz, rx, ry, rz), det);
            res.ay   = qdiv(dot(cxy, cyy, cyz, rx, ry, rz), det);
            res.az   = qdiv(dot(cxz, cyz, czz, rx, ry, rz), det);
            res.sing = 1'b0;
        end
        return res;
    endfunction

    // ---- drivers ----
    task automatic write_reg(logic [rbaa_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbaa_pkg::WORD_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rbaa_pkg::REG_IXX: tn_xx = val[rbaa_pkg::WORD_BITS-2:0];
            rbaa_pkg::REG_IYY: tn_yy = val[rbaa_pkg::WORD_BITS-2:0];
            rbaa_pkg::REG_IZZ: tn_zz = val[rbaa_pkg::WORD_BITS-2:0];
            rbaa_pkg::REG_IXY: tn_xy = val;
            rbaa_pkg::REG_IXZ: tn_xz = val;
            rbaa_pkg::REG_IYZ: tn_yz = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every result word is back, sender held off
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (accel_q.size() != 0) @(negedge i_clk);
    endtask

    // one input word; typed expectation used when given
    task automatic send_word(rbaa_pkg::t_word wx, wy, wz, tx, ty, tz, bit typed,
                             t_accel exp_typed);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 27) begin
            i_valid    <= 1'b0;
            i_omega_x  <= $urandom;
            i_torque_z <= $urandom;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_omega_x  <= wx;  i_omega_y  <= wy;  i_omega_z  <= wz;
        i_torque_x <= tx;  i_torque_y <= ty;  i_torque_z <= tz;
        do @(posedge i_clk); while (o_stall);
        accel_q.push_back(typed ? exp_typed : euler_accel(wx, wy, wz, tx, ty, tz));
    endtask

    function automatic rbaa_pkg::t_word rand_field(int unsigned span);
        if ($urandom_range(9) < 2) return $urandom;
        return rbaa_pkg::t_word'($urandom_range(2 * span)) - rbaa_pkg::t_word'(span);
    endfunction

    function automatic logic [rbaa_pkg::WORD_BITS-1:0] rand_diag();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(32'h0010_0000, 32'h0000_8000);
        endcase
    endfunction

    function automatic logic [rbaa_pkg::WORD_BITS-1:0] rand_offd();
        case ($urandom_range(9))
            0:       return 32'h0;
            1:       return W_MAX;
            2:       return W_MIN;
            3:       return $urandom;
            default: return rbaa_pkg::t_word'($urandom_range(32'h8000))
                            - rbaa_pkg::t_word'(32'h4000);
        endcase
    endfunction

    // ---- result side ----
    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !calm && ($urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        t_accel e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (accel_q.size() == 0) begin
                $display("%0t: result word with none expected: %h %h %h %b", $time,
                         o_accel_x, o_accel_y, o_accel_z, o_singular);
                n_err++;
            end else begin
                e = accel_q.pop_front();
                if (o_accel_x !== e.ax) begin
                    $display("%0t: accel_x exp %h got %h", $time, e.ax, o_accel_x);
                    n_err++;
                end
                if (o_accel_y !== e.ay) begin
                    $display("%0t: accel_y exp %h got %h", $time, e.ay, o_accel_y);
                    n_err++;
                end
                if (o_accel_z !== e.az) begin
                    $display("%0t: accel_z exp %h got %h", $time, e.az, o_accel_z);
                    n_err++;
                end
                if (o_singular !== e.sing) begin
                    $display("%0t: singular exp %b got %b", $time, e.sing, o_singular);
                    n_err++;
                end
            end
        end
    end

    // ---- sequence ----
    initial begin
        t_accel   ex;
        t_dir_row r;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIR; i++) begin
            r = DIR_TAB[i];
            if (r.kind == ROW_CFG) begin
                drain();
                write_reg(r.idx, r.val);
            end else begin
                ex = '{r.ex, r.ey, r.ez, r.es};
                send_word(r.wx, r.wy, r.wz, r.tx, r.ty, r.tz, r.typed, ex);
            end
        end
        // rest of the full-scale tensor
        drain();
        write_reg(rbaa_pkg::REG_IYY, 32'h7FFF_FFFF);
        write_reg(rbaa_pkg::REG_IZZ, 32'h7FFF_FFFF);
        write_reg(rbaa_pkg::REG_IXY, W_MIN);
        write_reg(rbaa_pkg::REG_IXZ, W_MAX);
        write_reg(rbaa_pkg::REG_IYZ, W_MIN);
        send_word(32'sh10000, -32'sh10000, 32'sh10000, W_MAX, W_MIN, 0, 1'b0, ex);
        send_word(0, 0, 0, 32'sh10000, 32'sh10000, 32'sh10000, 1'b0, ex);

        // random phases, each under a fresh tensor
        for (int ph = 0; ph < N_PHASE; ph++) begin
            drain();
            if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 6)), $urandom);
            write_reg(rbaa_pkg::REG_IXX, rand_diag());
            write_reg(rbaa_pkg::REG_IYY, rand_diag());
            write_reg(rbaa_pkg::REG_IZZ, rand_diag());
            write_reg(rbaa_pkg::REG_IXY, rand_offd());
            write_reg(rbaa_pkg::REG_IXZ, rand_offd());
            write_reg(rbaa_pkg::REG_IYZ, rand_offd());
            calm = (ph == 3);
            for (int k = 0; k < PHASE_LEN; k++) begin
                send_word(rand_field(32'h40000), rand_field(32'h40000),
                          rand_field(32'h40000), rand_field(32'h80_0000),
                          rand_field(32'h80_0000), rand_field(32'h80_0000), 1'b0, ex);
            end
            calm = 1'b0;
        end

        drain();
        repeat (rbaa_pkg::LAT + 8) @(posedge i_clk);
        if (n_err == 0 && accel_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
